/* sv/lhe_pkg.sv */
// shared types and constants of the luma histogram engine
package lhe_pkg;

    localparam int BIN_COUNT = 256;
    localparam int BIN_BITS  = 8;
    localparam int NORM_BITS = 8;

    // q16 luma weights, they sum to 65536
    localparam logic [15:0] W_CH0    = 16'd19595;
    localparam logic [15:0] W_CH1    = 16'd38470;
    localparam logic [15:0] W_CH2    = 16'd7471;
    localparam logic [15:0] Q16_HALF = 16'd32768;

    typedef enum logic [1:0] {
        OP_ACC   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_DRAIN,
        ST_RD_DATA,
        ST_DIV,
        ST_CLR_DRAIN
    } t_state;

    typedef struct packed {
        logic acc_vld;
        logic rd_req;
        logic clr;
    } t_mem_ctl;

endpackage

/* sv/lhe_luma.sv */
// registered rgb to luma conversion, q16 with rounding
module lhe_luma import lhe_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic [7:0]          i_chan0,
    input  logic [7:0]          i_chan1,
    input  logic [7:0]          i_chan2,
    output logic                o_vld,
    output logic [BIN_BITS-1:0] o_gray
);

    logic [23:0]         n_sum;
    logic                r_vld;
    logic [BIN_BITS-1:0] r_gray;

    assign n_sum = 24'(W_CH0) * 24'(i_chan0) + 24'(W_CH1) * 24'(i_chan1)
                 + 24'(W_CH2) * 24'(i_chan2) + 24'(Q16_HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_gray <= n_sum[23:16];
        end
    end

    assign o_vld  = r_vld;
    assign o_gray = r_gray;

endmodule

/* sv/lhe_bin_mem.sv */
// bin counter memory with read-modify-write and write forwarding
module lhe_bin_mem import lhe_pkg::*; #(
    parameter int COUNT_BITS = 23
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_mem_ctl              i_ctl,
    input  logic [BIN_BITS-1:0]   i_acc_gray,
    input  logic [BIN_BITS-1:0]   i_rd_addr,
    output logic                  o_pipe_busy,
    output logic [COUNT_BITS-1:0] o_rd_cnt
);

    localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] r_mem [BIN_COUNT];
    logic [BIN_COUNT-1:0]  r_vld_bits;
    logic [COUNT_BITS-1:0] r_rd_data;
    logic                  r_rd_vld;
    logic                  r_s2_vld;
    logic [BIN_BITS-1:0]   r_s2_gray;
    logic                  r_wr_vld;
    logic [BIN_BITS-1:0]   r_wr_gray;
    logic [COUNT_BITS-1:0] r_wr_data;

    logic [BIN_BITS-1:0]   n_rd_addr;
    logic [COUNT_BITS-1:0] n_cur;
    logic [COUNT_BITS-1:0] n_wr_data;

    assign n_rd_addr = i_ctl.rd_req ? i_rd_addr : i_acc_gray;

    // the write of the previous cycle is not yet seen by the read
    always_comb begin
        if (r_wr_vld && (r_wr_gray == r_s2_gray)) begin
            n_cur = r_wr_data;
        end else if (r_rd_vld) begin
            n_cur = r_rd_data;
        end else begin
            n_cur = '0;
        end
        n_wr_data = (n_cur == CountMax) ? n_cur : n_cur + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[n_rd_addr];
        if (r_s2_vld) begin
            r_mem[r_s2_gray] <= n_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_bits <= '0;
            r_s2_vld   <= 1'b0;
            r_wr_vld   <= 1'b0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (i_ctl.clr) begin
                r_vld_bits <= '0;
            end else if (r_s2_vld) begin
                r_vld_bits[r_s2_gray] <= 1'b1;
            end
            r_s2_vld <= i_ctl.acc_vld;
            r_wr_vld <= r_s2_vld;
            r_rd_vld <= r_vld_bits[n_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_gray <= i_acc_gray;
        r_wr_gray <= r_s2_gray;
        r_wr_data <= n_wr_data;
    end

    assign o_pipe_busy = r_s2_vld;
    assign o_rd_cnt    = r_rd_vld ? r_rd_data : '0;

endmodule

/* sv/lhe_div.sv */
// restoring divider for floor(num*255/den), one quotient bit per cycle
module lhe_div import lhe_pkg::*; #(
    parameter int COUNT_BITS = 23
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COUNT_BITS-1:0] i_num,
    input  logic [COUNT_BITS-1:0] i_den,
    output logic                  o_done,
    output logic [NORM_BITS-1:0]  o_quot
);

    localparam int RW = COUNT_BITS + NORM_BITS;

    logic [RW-1:0]        r_rem;
    logic [RW-1:0]        r_den_sh;
    logic [NORM_BITS-1:0] r_quot;
    logic [2:0]           r_step;
    logic                 r_run;
    logic                 r_done;

    logic                 n_ge;

    assign n_ge = (r_rem >= r_den_sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_step == 3'd0)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // num*255 as num*256 - num
            r_rem    <= {i_num, {NORM_BITS{1'b0}}} - {{NORM_BITS{1'b0}}, i_num};
            r_den_sh <= {1'b0, i_den, {(NORM_BITS-1){1'b0}}};
            r_quot   <= '0;
            r_step   <= 3'd7;
        end else if (r_run) begin
            if (n_ge) begin
                r_rem <= r_rem - r_den_sh;
            end
            r_quot   <= {r_quot[NORM_BITS-2:0], n_ge};
            r_den_sh <= r_den_sh >> 1;
            r_step   <= r_step - 3'd1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* sv/luma_histogram_engine.sv */
// top level of the luma histogram engine: command decode, sequencing and result register
// accumulate: 1 transaction per cycle, busy stays low, count lands via luma reg and RMW
// read: busy through the pipeline drain, one memory read and the 8-step divider; the
//   one-cycle o_valid strobe, which cannot be stalled, is registered from the divider's done
// clear: waits for accumulates in flight, then drops all bins and the total at once
// reset clears every bin and the total at once via per-bin valid bits, no sweep
module luma_histogram_engine import lhe_pkg::*; #(
    parameter int COUNT_BITS = 23
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_operation,
    input  logic [7:0]            i_chan0,
    input  logic [7:0]            i_chan1,
    input  logic [7:0]            i_chan2,
    input  logic [7:0]            i_bin_index,
    output logic                  o_valid,
    output logic [7:0]            o_bin_number,
    output logic [COUNT_BITS-1:0] o_raw_count,
    output logic [7:0]            o_normalized
);

    localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

    t_state                r_state;
    t_state                n_state;
    logic [BIN_BITS-1:0]   r_bin;
    logic [COUNT_BITS-1:0] r_total;
    logic [COUNT_BITS-1:0] r_cnt;
    logic                  r_tot_zero;
    logic                  r_o_valid;
    logic [BIN_BITS-1:0]   r_o_bin;
    logic [COUNT_BITS-1:0] r_o_cnt;
    logic [NORM_BITS-1:0]  r_o_norm;

    t_op                   n_op;
    logic                  n_accept;
    logic                  n_acc_load;
    logic                  n_pipe_empty;
    logic                  n_div_start;
    t_mem_ctl              n_ctl;

    logic                  luma_vld;
    logic [BIN_BITS-1:0]   luma_gray;
    logic                  mem_busy;
    logic [COUNT_BITS-1:0] mem_cnt;
    logic                  div_done;
    logic [NORM_BITS-1:0]  div_quot;

    assign busy       = (r_state != ST_IDLE);
    assign n_accept   = start && !busy;
    assign n_op       = t_op'(i_operation);
    assign n_acc_load = n_accept && (n_op == OP_ACC);

    // no accumulate left in the luma stage or in the memory read-modify-write
    assign n_pipe_empty = !luma_vld && !mem_busy;

    lhe_luma u_luma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (n_acc_load),
        .i_chan0 (i_chan0),
        .i_chan1 (i_chan1),
        .i_chan2 (i_chan2),
        .o_vld   (luma_vld),
        .o_gray  (luma_gray)
    );

    lhe_bin_mem #(.COUNT_BITS(COUNT_BITS)) u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (n_ctl),
        .i_acc_gray  (luma_gray),
        .i_rd_addr   (r_bin),
        .o_pipe_busy (mem_busy),
        .o_rd_cnt    (mem_cnt)
    );

    lhe_div #(.COUNT_BITS(COUNT_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_div_start),
        .i_num   (mem_cnt),
        .i_den   (r_total),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_ctl.acc_vld = luma_vld;
        n_ctl.rd_req  = 1'b0;
        n_ctl.clr     = 1'b0;
        n_div_start   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (n_accept) begin
                    case (n_op)
                        OP_READ:  n_state = ST_RD_DRAIN;
                        OP_CLEAR: n_state = ST_CLR_DRAIN;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RD_DRAIN: begin
                if (n_pipe_empty) begin
                    n_ctl.rd_req = 1'b1;
                    n_state      = ST_RD_DATA;
                end
            end
            ST_RD_DATA: begin
                // bin count is on the memory read port this cycle
                n_div_start = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CLR_DRAIN: begin
                if (n_pipe_empty) begin
                    n_ctl.clr = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_total   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // saturating pixel total, counted at accept
            if (n_ctl.clr) begin
                r_total <= '0;
            end else if (n_acc_load && (r_total != CountMax)) begin
                r_total <= r_total + 1'b1;
            end
            r_o_valid <= (r_state == ST_DIV) && div_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept && (n_op == OP_READ)) begin
            r_bin <= i_bin_index;
        end
        if (n_div_start) begin
            r_cnt      <= mem_cnt;
            r_tot_zero <= (r_total == '0);
        end
        if ((r_state == ST_DIV) && div_done) begin
            r_o_bin  <= r_bin;
            r_o_cnt  <= r_cnt;
            r_o_norm <= r_tot_zero ? '0 : div_quot;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_bin_number = r_o_bin;
    assign o_raw_count  = r_o_cnt;
    assign o_normalized = r_o_norm;

endmodule

/* bench/testbench.sv */
// self-checking bench for the luma histogram engine: scoreboard, command driver, result monitor
`timescale 1ns / 1ps

module testbench;
    import lhe_pkg::*;

    localparam int CNT_BITS = 23;
    localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 650;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [7:0]          bin;
        logic [CNT_BITS-1:0] count;
        logic [7:0]          norm;
    } t_bin_report;

    // mirrors the histogram state and queues the bin reports that reads will produce
    class histogram_scoreboard;
        logic [CNT_BITS-1:0] bin_tally [BIN_COUNT];
        logic [CNT_BITS-1:0] pixel_tally;
        t_bin_report         pending_reports[$];
        int                  errors;

        function new();
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (bin_tally[k]) bin_tally[k] = '0;
            pixel_tally = '0;
        endfunction

        // q16 weighted sum with rounding, weights add up to one
        function logic [7:0] gray_level(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
            logic [31:0] acc;
            acc = 32'(W_CH0) * c0 + 32'(W_CH1) * c1 + 32'(W_CH2) * c2 + 32'(Q16_HALF);
            return (acc[31:16] > 255) ? 8'd255 : acc[23:16];
        endfunction

        function logic [CNT_BITS-1:0] bump(logic [CNT_BITS-1:0] v);
            return (v == CNT_MAX) ? v : v + 1'b1;
        endfunction

        function void note_command(logic [1:0] op, logic [7:0] c0, logic [7:0] c1,
                                   logic [7:0] c2, logic [7:0] idx);
            logic [7:0]         g;
            longint unsigned    q;
            t_bin_report        rep;
            case (op)
                OP_ACC: begin
                    g = gray_level(c0, c1, c2);
                    bin_tally[g] = bump(bin_tally[g]);
                    pixel_tally  = bump(pixel_tally);
                end
                OP_READ: begin
                    q = 0;
                    if (pixel_tally != 0) begin
                        q = (longint'(bin_tally[idx]) * 255) / longint'(pixel_tally);
                        if (q > 255) q = 255;
                    end
                    rep.bin   = idx;
                    rep.count = bin_tally[idx];
                    rep.norm  = q[7:0];
                    pending_reports.push_back(rep);
                end
                OP_CLEAR: wipe();
                default: ;  // unused code leaves the histogram alone
            endcase
        endfunction

        function void check_result(logic [7:0] bin, logic [CNT_BITS-1:0] cnt, logic [7:0] norm);
            t_bin_report exp_rep;
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected bin report: bin %0d count %0d norm %0d",
                         $time, bin, cnt, norm);
                errors++;
                return;
            end
            exp_rep = pending_reports.pop_front();
            if (bin !== exp_rep.bin) begin
                $display("%0t: bin_number expected %0d actual %0d", $time, exp_rep.bin, bin);
                errors++;
            end
            if (cnt !== exp_rep.count) begin
                $display("%0t: raw_count of bin %0d expected %0d actual %0d",
                         $time, exp_rep.bin, exp_rep.count, cnt);
                errors++;
            end
            if (norm !== exp_rep.norm) begin
                $display("%0t: normalized of bin %0d expected %0d actual %0d",
                         $time, exp_rep.bin, exp_rep.norm, norm);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          i_operation;
    logic [7:0]          i_chan0;
    logic [7:0]          i_chan1;
    logic [7:0]          i_chan2;
    logic [7:0]          i_bin_index;
    logic                o_valid;
    logic [7:0]          o_bin_number;
    logic [CNT_BITS-1:0] o_raw_count;
    logic [7:0]          o_normalized;

    histogram_scoreboard sb = new();

    // small color palette so that some bins collect many pixels
    logic [7:0] pal0 [4];
    logic [7:0] pal1 [4];
    logic [7:0] pal2 [4];

    luma_histogram_engine #(.COUNT_BITS(CNT_BITS)) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_chan0      (i_chan0),
        .i_chan1      (i_chan1),
        .i_chan2      (i_chan2),
        .i_bin_index  (i_bin_index),
        .o_valid      (o_valid),
        .o_bin_number (o_bin_number),
        .o_raw_count  (o_raw_count),
        .o_normalized (o_normalized)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // one transaction: drive at the falling edge, hold until accepted at a rising edge
    task automatic issue(input logic [1:0] op, input logic [7:0] c0, input logic [7:0] c1,
                         input logic [7:0] c2, input logic [7:0] idx);
        @(negedge i_clk);
        start       <= 1'b1;
        i_operation <= op;
        i_chan0     <= c0;
        i_chan1     <= c1;
        i_chan2     <= c2;
        i_bin_index <= idx;
        do @(posedge i_clk); while (busy);
        sb.note_command(op, c0, c1, c2, idx);
    endtask

    // sender gap, payload wiggles while start is low
    task automatic pause(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start       <= 1'b0;
            i_operation <= 2'($urandom);
            i_chan0     <= 8'($urandom);
            i_chan1     <= 8'($urandom);
            i_chan2     <= 8'($urandom);
            i_bin_index <= 8'($urandom);
        end
    endtask

    // results cannot be held off, so every strobe is checked
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_bin_number, o_raw_count, o_normalized);
    end

    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [1:0] op;
        logic [7:0] c0, c1, c2, idx;
        int         roll, slot, accepted, burst_left, pick;

        start       = 1'b0;
        i_rst_n     = 1'b0;
        i_operation = OP_ACC;
        i_chan0     = '0;
        i_chan1     = '0;
        i_chan2     = '0;
        i_bin_index = '0;
        foreach (pal0[k]) begin
            pal0[k] = 8'($urandom);
            pal1[k] = 8'($urandom);
            pal2[k] = 8'($urandom);
        end
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reads on an empty histogram, total zero
        issue(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0);
        issue(OP_READ, 8'd0, 8'd0, 8'd0, 8'd255);
        // channel extremes and each weight on its own
        issue(OP_ACC, 8'd0, 8'd0, 8'd0, 8'd0);
        issue(OP_ACC, 8'd255, 8'd255, 8'd255, 8'd0);
        issue(OP_ACC, 8'd255, 8'd0, 8'd0, 8'd0);
        issue(OP_ACC, 8'd0, 8'd255, 8'd0, 8'd0);
        issue(OP_ACC, 8'd0, 8'd0, 8'd255, 8'd0);
        issue(OP_ACC, 8'd170, 8'd85, 8'd51, 8'd0);
        // unused code must change nothing
        issue(OP_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255);
        issue(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0);
        issue(OP_READ, 8'd0, 8'd0, 8'd0, 8'd255);
        issue(OP_READ, 8'd0, 8'd0, 8'd0, sb.gray_level(8'd255, 8'd0, 8'd0));
        issue(OP_READ, 8'd0, 8'd0, 8'd0, sb.gray_level(8'd0, 8'd255, 8'd0));
        issue(OP_READ, 8'd0, 8'd0, 8'd0, sb.gray_level(8'd0, 8'd0, 8'd255));
        // clear, then a read back at total zero
        issue(OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0);
        issue(OP_READ, 8'd0, 8'd0, 8'd0, sb.gray_level(8'd255, 8'd0, 8'd0));
        // one bin holding every pixel gives full scale
        issue(OP_ACC, 8'd0, 8'd0, 8'd0, 8'd0);
        issue(OP_ACC, 8'd0, 8'd0, 8'd0, 8'd0);
        issue(OP_ACC, 8'd0, 8'd0, 8'd0, 8'd0);
        issue(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0);
        issue(OP_ACC, 8'd255, 8'd255, 8'd255, 8'd0);
        issue(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0);
        issue(OP_READ, 8'd0, 8'd0, 8'd0, 8'd255);

        // random traffic in bursts, mostly pixels with reads aimed at filled bins
        accepted   = 0;
        burst_left = 0;
        while (accepted < RANDOM_ITEMS) begin
            if (burst_left == 0) begin
                pick = $urandom_range(0, 3);
                pause(pick == 0 ? 0 : (pick == 3 ? $urandom_range(8, 20) : $urandom_range(1, 4)));
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            roll = $urandom_range(0, 99);
            if (roll < 4)       op = OP_UNUSED;
            else if (roll < 7)  op = OP_CLEAR;
            else if (roll < 22) op = OP_READ;
            else                op = OP_ACC;
            c0   = 8'($urandom);
            c1   = 8'($urandom);
            c2   = 8'($urandom);
            idx  = 8'($urandom);
            slot = $urandom_range(0, 3);
            roll = $urandom_range(0, 99);
            if (op == OP_ACC) begin
                if ($urandom_range(0, 15) == 0) begin
                    pal0[slot] = 8'($urandom);
                    pal1[slot] = 8'($urandom);
                    pal2[slot] = 8'($urandom);
                end
                if (roll < 45) begin
                    c0 = pal0[slot];
                    c1 = pal1[slot];
                    c2 = pal2[slot];
                end else if (roll < 60) begin
                    c1 = c0;
                    c2 = c0;
                end
            end else if (op == OP_READ && roll < 60) begin
                idx = sb.gray_level(pal0[slot], pal1[slot], pal2[slot]);
            end
            issue(op, c0, c1, c2, idx);
            if (op != OP_UNUSED) accepted++;
        end
        pause(1);

        while (sb.pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_reports.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
